### hw/rtl/common_neighbor_analysis_classifier_defines.svh
// Assertion macros for the common neighbor analysis classifier
`ifndef COMMON_NEIGHBOR_ANALYSIS_CLASSIFIER_DEFINES_SVH
`define COMMON_NEIGHBOR_ANALYSIS_CLASSIFIER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define CNA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CNA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hw/rtl/cna_pkg.sv
// Package: types and constants of the common neighbor analysis classifier
`default_nettype none
package cna_pkg;
  localparam int AtomW = 12;
  localparam int NAtoms = 4096;
  localparam int SlotW = 5;
  localparam int NSlots = 32;
  localparam int CntW = 6;
  localparam int CSlots = 16;
  localparam int CIdxW = 4;

  localparam logic [1:0] ACT_COUNT = 2'd0;
  localparam logic [1:0] ACT_SLOT = 2'd1;
  localparam logic [1:0] ACT_CLASSIFY = 2'd2;

  localparam logic [2:0] CLS_FCC = 3'd0;
  localparam logic [2:0] CLS_HCP = 3'd1;
  localparam logic [2:0] CLS_BCC = 3'd2;
  localparam logic [2:0] CLS_ICO = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [AtomW-1:0] atom_id;
    logic [SlotW-1:0] slot;
    logic [AtomW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [AtomW-1:0] atom_echo;
    logic [2:0] pattern_class;
  } out_item_t;
endpackage
`default_nettype wire

### hw/rtl/common_neighbor_analysis_classifier.sv
// Top level: neighbor table memories and the classify sequencer
// Load transactions leave busy low.
// A classify transaction reads neighbor lists and counts one entry at a time through
// the one read port of each table memory; busy stays high until it completes.
// A neighbor count other than 12 or 14 goes straight to the result as CLS_OTHER.
// Results appear one cycle on out_valid; reset clears control state only.
`default_nettype none
module common_neighbor_analysis_classifier (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire cna_pkg::in_item_t   in_item,
  output logic                     out_valid,
  output cna_pkg::out_item_t       out_item
);
  import cna_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_NI   = 11'b00000000010,
    S_AJ   = 11'b00000000100,
    S_NJ   = 11'b00000001000,
    S_PV   = 11'b00000010000,
    S_QV   = 11'b00000100000,
    S_BC   = 11'b00001000000,
    S_BS   = 11'b00010000000,
    S_SIG  = 11'b00100000000,
    S_FIN  = 11'b01000000000,
    S_CNT0 = 11'b10000000000
  } state_t;

  logic [AtomW-1:0] idx_mem [NSlots*NAtoms];
  logic [CntW-1:0] cnt_mem [NAtoms];
  logic [AtomW-1:0] common_r [CSlots];
  logic [CIdxW:0] tally_r [CSlots];

  state_t state_r, state_nxt;
  logic [AtomW-1:0] ai_r, aj_r, v_r, atom_r;
  logic [CntW-1:0] ni_r, nj_r, cnt_rd;
  logic [AtomW-1:0] idx_rd;
  logic [SlotW-1:0] m_r, p_r;
  logic [CntW-1:0] q_r, s_r;
  logic [CntW-1:0] nb_cnt_r;
  logic [4:0] ncom_r;
  logic [CIdxW-1:0] bp_r;
  logic [CIdxW:0] bq_r;
  logic [6:0] nbonds_r;
  logic [3:0] sig_r [5];
  logic [4:0] maxb_r, minb_r;
  logic [CIdxW:0] ti_r;

  logic [SlotW+AtomW-1:0] idx_addr;
  logic [AtomW-1:0] cnt_addr;
  logic rd_pend_r;
  logic load_go;
  logic [4:0] kept;

  assign busy = (state_r != S_IDLE);
  assign load_go = start && !busy;
  assign kept = (ncom_r > 5'(CSlots)) ? 5'(CSlots) : ncom_r;

  // table memories: load writes, one registered read each
  always_ff @(posedge clk) begin
    if (load_go && in_item.action == ACT_COUNT)
      cnt_mem[in_item.atom_id] <= (in_item.value > AtomW'(NSlots)) ?
        CntW'(NSlots) : in_item.value[CntW-1:0];
    if (load_go && in_item.action == ACT_SLOT)
      idx_mem[{in_item.atom_id, in_item.slot}] <= in_item.value;
    idx_rd <= idx_mem[idx_addr];
    cnt_rd <= cnt_mem[cnt_addr];
  end

  // one read address per memory, chosen by state
  always_comb begin
    idx_addr = {ai_r, m_r};
    cnt_addr = ai_r;
    unique case (state_r)
      S_IDLE: cnt_addr = in_item.atom_id;
      S_AJ:   idx_addr = {ai_r, m_r};
      S_NJ:   cnt_addr = aj_r;
      S_PV:   idx_addr = {ai_r, p_r};
      S_QV:   idx_addr = {aj_r, q_r[SlotW-1:0]};
      S_CNT0: cnt_addr = atom_r;
      S_BS:   idx_addr = {atom_r, s_r[SlotW-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rd_pend_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == S_FIN);
      unique case (state_r)
        S_IDLE: if (load_go && in_item.action == ACT_CLASSIFY) begin
          ai_r <= in_item.atom_id;
          out_item.atom_echo <= in_item.atom_id;
          for (int i = 0; i < 5; i++) sig_r[i] <= '0;
          m_r <= '0;
          state_r <= S_NI;
        end
        S_NI: begin
          ni_r <= cnt_rd;
          if (cnt_rd != 6'd12 && cnt_rd != 6'd14) begin
            out_item.pattern_class <= CLS_OTHER;
            state_r <= S_FIN;
          end else begin
            rd_pend_r <= 1'b0;
            state_r <= S_AJ;
          end
        end
        S_AJ: begin
          if (rd_pend_r) begin
            aj_r <= idx_rd;
            rd_pend_r <= 1'b0;
            state_r <= S_NJ;
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        S_NJ: begin
          if (rd_pend_r) begin
            nj_r <= cnt_rd;
            ncom_r <= '0;
            p_r <= '0;
            rd_pend_r <= 1'b0;
            state_r <= S_PV;
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        S_PV: begin
          if (6'(p_r) >= ni_r) begin
            for (int i = 0; i < CSlots; i++) tally_r[i] <= '0;
            nbonds_r <= '0; bp_r <= '0; bq_r <= 5'd1;
            rd_pend_r <= 1'b0;
            state_r <= S_BC;
          end else if (rd_pend_r) begin
            v_r <= idx_rd;
            q_r <= '0;
            rd_pend_r <= 1'b0;
            state_r <= S_QV;
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        S_QV: begin
          if (q_r >= nj_r) begin
            p_r <= p_r + 5'd1;
            rd_pend_r <= 1'b0;
            state_r <= S_PV;
          end else if (rd_pend_r) begin
            if (idx_rd == v_r) begin
              if (ncom_r < 5'(CSlots)) common_r[ncom_r[CIdxW-1:0]] <= v_r;
              if (ncom_r != 5'd31) ncom_r <= ncom_r + 5'd1;
            end
            q_r <= q_r + 6'd1;
            rd_pend_r <= 1'b0;
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        S_BC: begin
          if (5'(bp_r) + 5'd1 >= kept) begin
            ti_r <= '0; maxb_r <= '0; minb_r <= 5'(CSlots);
            state_r <= S_SIG;
          end else if (bq_r >= kept) begin
            bp_r <= bp_r + 4'd1;
            bq_r <= {1'b0, bp_r} + 5'd2;
          end else begin
            atom_r <= common_r[bp_r];
            rd_pend_r <= 1'b0;
            state_r <= S_CNT0;
          end
        end
        S_CNT0: begin
          if (rd_pend_r) begin
            nb_cnt_r <= cnt_rd;
            s_r <= '0;
            rd_pend_r <= 1'b0;
            state_r <= S_BS;
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        S_BS: begin
          if (s_r >= nb_cnt_r) begin
            bq_r <= bq_r + 5'd1;
            rd_pend_r <= 1'b0;
            state_r <= S_BC;
          end else if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            if (idx_rd == common_r[bq_r[CIdxW-1:0]]) begin
              nbonds_r <= nbonds_r + 7'd1;
              tally_r[bp_r] <= tally_r[bp_r] + 5'd1;
              tally_r[bq_r[CIdxW-1:0]] <= tally_r[bq_r[CIdxW-1:0]] + 5'd1;
              bq_r <= bq_r + 5'd1;
              state_r <= S_BC;
            end else begin
              s_r <= s_r + 6'd1;
            end
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        S_SIG: begin
          if (ti_r < kept) begin
            if (tally_r[ti_r[CIdxW-1:0]] > maxb_r) maxb_r <= tally_r[ti_r[CIdxW-1:0]];
            if (tally_r[ti_r[CIdxW-1:0]] < minb_r) minb_r <= tally_r[ti_r[CIdxW-1:0]];
            ti_r <= ti_r + 5'd1;
          end else begin
            if (ni_r == 6'd12) begin
              if (ncom_r == 5'd4 && nbonds_r == 7'd2 && maxb_r == 5'd1 && minb_r == 5'd1)
                sig_r[0] <= sig_r[0] + 4'd1;
              else if (ncom_r == 5'd4 && nbonds_r == 7'd2 && maxb_r == 5'd2 &&
                       minb_r == 5'd0)
                sig_r[1] <= sig_r[1] + 4'd1;
              else if (ncom_r == 5'd5 && nbonds_r == 7'd5 && maxb_r == 5'd2 &&
                       minb_r == 5'd2)
                sig_r[2] <= sig_r[2] + 4'd1;
            end else begin
              if (ncom_r == 5'd4 && nbonds_r == 7'd4 && maxb_r == 5'd2 && minb_r == 5'd2)
                sig_r[3] <= sig_r[3] + 4'd1;
              else if (ncom_r == 5'd6 && nbonds_r == 7'd6 && maxb_r == 5'd2 &&
                       minb_r == 5'd2)
                sig_r[4] <= sig_r[4] + 4'd1;
            end
            if (6'(m_r) + 6'd1 >= ni_r) begin
              state_r <= S_FIN;
              out_item.pattern_class <= CLS_OTHER;
            end else begin
              m_r <= m_r + 5'd1;
              rd_pend_r <= 1'b0;
              state_r <= S_AJ;
            end
          end
        end
        S_FIN: begin
          if (ni_r == 6'd12) begin
            if (sig_r[0] == 4'd12) out_item.pattern_class <= CLS_FCC;
            else if (sig_r[0] == 4'd6 && sig_r[1] == 4'd6)
              out_item.pattern_class <= CLS_HCP;
            else if (sig_r[2] == 4'd12) out_item.pattern_class <= CLS_ICO;
            else out_item.pattern_class <= CLS_OTHER;
          end else if (ni_r == 6'd14 && sig_r[3] == 4'd6 && sig_r[4] == 4'd8)
            out_item.pattern_class <= CLS_BCC;
          else out_item.pattern_class <= CLS_OTHER;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/cna_checker.sv
// Port-level checker for the classifier, bound to the top level
`default_nettype none
`include "common_neighbor_analysis_classifier_defines.svh"
module cna_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire cna_pkg::in_item_t in_item,
  input wire cna_pkg::out_item_t out_item
);
  import cna_pkg::*;
  `CNA_ASSERT_NXT(a_one_shot, clk, rst_n, out_valid, !out_valid)
  `CNA_ASSERT_IMP(a_class_range, clk, rst_n, out_valid, out_item.pattern_class <= CLS_OTHER)
  `CNA_ASSERT_NXT(a_load_no_busy, clk, rst_n, start && !busy && in_item.action != ACT_CLASSIFY, !busy)
  `CNA_ASSERT_NXT(a_classify_busy, clk, rst_n, start && !busy && in_item.action == ACT_CLASSIFY, busy)
endmodule

bind common_neighbor_analysis_classifier cna_checker u_cna_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .in_item(in_item), .out_item(out_item)
);
`default_nettype wire
